[rtl/utcc_pkg.sv]
// Shared types, constants and helpers for the Unix time / calendar converter.
// Depends on nothing; imported by unix_time_calendar_converter.
package utcc_pkg;

  // Valid span of signed seconds: 0000-01-01T00:00:00 .. 9999-12-31T23:59:59
  localparam logic signed [38:0] SecLow     = -39'sd62167219200;
  localparam logic signed [38:0] SecHigh    = 39'sd253402300799;
  localparam logic [38:0]        SecLowNeg  = 39'd62167219200;

  localparam logic [22:0] JdnBias   = 23'd32045;
  localparam logic [22:0] ShiftA    = 23'd1753104;   // days offset + 32044
  localparam logic [23:0] WdayBias  = 24'd1721061;   // days offset to JDN, plus one
  localparam logic signed [24:0] EpochJdn = 25'sd2440588;
  localparam logic signed [41:0] DaySec   = 42'sd86400;

  // Reciprocals for exact division: ceil(2^k / d), k = numerator bits + divisor bits
  localparam logic [32:0] M675  = 33'(((64'd1 << 42) + 64'd674) / 64'd675);
  localparam logic [25:0] M146k = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
  localparam logic [18:0] M1461 = 19'(((64'd1 << 29) + 64'd1460) / 64'd1461);
  localparam logic [11:0] M153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [17:0] M3600 = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] M60   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [15:0] M100  = 16'(((64'd1 << 22) + 64'd99) / 64'd100);

  // One pipeline stage; both directions travel side by side
  typedef struct packed {
    logic                cmd;
    logic [38:0]         sec_raw;
    logic                in_rng;
    logic [14:0]         y;
    logic [7:0]          yh;
    logic [22:0]         jdn;
    logic [16:0]         tod;
    logic signed [41:0]  fs;
    logic                f_oor;
    logic [2:0]          wd;
    logic [31:0]         v;
    logic [6:0]          lo7;
    logic [21:0]         q;
    logic [16:0]         rem;
    logic [22:0]         a;
    logic [7:0]          b;
    logic [4:0]          hr;
    logic [15:0]         c;
    logic [11:0]         r2;
    logic [6:0]          d;
    logic [5:0]          mi;
    logic [8:0]          e;
    logic [5:0]          se;
    logic [3:0]          mm;
  } utcc_stage_t;

  // Days before a March-based month: (153 m + 2) / 5
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd398;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

  // Remainder by 7: octal digits sum, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [23:0] x);
    logic [5:0] s;
    logic [3:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(x[3*i +: 3]);
    end
    t = 4'(s[2:0]) + 4'(s[5:3]);
    return (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
  endfunction

endpackage

[rtl/unix_time_calendar_converter.sv]
// Unix seconds <-> proleptic Gregorian date-time converter, nine-stage pipeline.
// Depends on utcc_pkg (stage struct, reciprocal constants, month and mod-7 helpers).
//
// Usage:
//   Input channel in_valid/in_ready carries one request: in_cmd = 0 turns
//   year/month/day/hour/minute/second into seconds, in_cmd = 1 turns signed
//   seconds into the civil fields. Both give the weekday (0 = Sunday).
//   Result channel out_valid/out_ready returns one result per request, in order.
//   Throughput: one request per cycle while the receiver takes results; each
//   stage holds about one constant multiplication, and the longest chain is
//   the seconds-to-date path of divisions by 86400, 146097, 1461 and 153,
//   each done by reciprocal multiplication.
//   Out-of-span times set out_out_of_range and zero the date fields.
//   Reset (rst_n low, synchronous) empties the pipeline; no clearing pass.
//   When the receiver stalls, the whole pipeline holds and in_ready drops;
//   while the output register is empty in_ready stays high.
module unix_time_calendar_converter
  import utcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic signed [38:0] in_seconds_in,
  input  logic [13:0]        in_year_in,
  input  logic [3:0]         in_month_in,
  input  logic [4:0]         in_day_in,
  input  logic [4:0]         in_hour_in,
  input  logic [5:0]         in_minute_in,
  input  logic [5:0]         in_second_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [38:0] out_seconds_out,
  output logic [13:0]        out_year_out,
  output logic [3:0]         out_month_out,
  output logic [4:0]         out_day_out,
  output logic [4:0]         out_hour_out,
  output logic [5:0]         out_minute_out,
  output logic [5:0]         out_second_out,
  output logic [2:0]         out_weekday,
  output logic               out_out_of_range
);

  utcc_stage_t st_r   [1:8];
  utcc_stage_t st_nxt [1:8];
  logic [8:1]  vld_r;
  logic        out_valid_r;
  logic        adv;

  logic [38:0] sec_out_r, sec_out_nxt;
  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic        oor_r, oor_nxt;

  // Advance the whole pipeline unless the result register is held
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage 1: capture request, form shifted year, month offset and offset seconds
  always_comb begin
    logic       lt3;
    logic [3:0] mp;
    logic [38:0] u;
    st_nxt[1] = '0;
    lt3 = (in_month_in <= 4'd2);
    mp  = lt3 ? 4'(in_month_in + 4'd9) : 4'(in_month_in - 4'd3);
    u   = 39'(in_seconds_in) + SecLowNeg;
    st_nxt[1].cmd     = in_cmd;
    st_nxt[1].sec_raw = in_seconds_in;
    st_nxt[1].in_rng  = (in_seconds_in >= SecLow) && (in_seconds_in <= SecHigh);
    st_nxt[1].y       = 15'(in_year_in) + 15'd4800 - 15'(lt3);
    st_nxt[1].jdn     = 23'(in_day_in) + 23'(month_offset(mp));
    st_nxt[1].tod     = 17'(in_hour_in) * 17'd3600 + 17'(in_minute_in) * 17'd60
                        + 17'(in_second_in);
    st_nxt[1].v       = u[38:7];
    st_nxt[1].lo7     = u[6:0];
  end

  // Stage 2: century count of the year; day count by reciprocal of 675
  always_comb begin
    logic [29:0] py;
    logic [64:0] pq;
    st_nxt[2] = st_r[1];
    py = 30'(st_r[1].y) * 30'(M100);
    pq = 65'(st_r[1].v) * 65'(M675);
    st_nxt[2].yh  = py[29:22];
    st_nxt[2].jdn = st_r[1].jdn + 23'(st_r[1].y) * 23'd365 + 23'(st_r[1].y >> 2);
    st_nxt[2].q   = pq[63:42];
  end

  // Stage 3: finish the Julian day; remainder seconds of the day
  always_comb begin
    logic [31:0] r;
    st_nxt[3] = st_r[2];
    r = st_r[2].v - 32'(st_r[2].q) * 32'd675;
    st_nxt[3].jdn = st_r[2].jdn - 23'(st_r[2].yh) + 23'(st_r[2].yh >> 2) - JdnBias;
    st_nxt[3].rem = {r[9:0], st_r[2].lo7};
    st_nxt[3].a   = 23'(st_r[2].q) + ShiftA;
  end

  // Stage 4: seconds from the day number; 400-year cycle, hour, weekday
  always_comb begin
    logic signed [24:0] dd;
    logic signed [41:0] dd42;
    logic [50:0] pb;
    logic [34:0] ph;
    st_nxt[4] = st_r[3];
    dd   = $signed({2'b00, st_r[3].jdn}) - EpochJdn;
    dd42 = 42'(dd);
    pb   = 51'({st_r[3].a, 2'b11}) * 51'(M146k);
    ph   = 35'(st_r[3].rem) * 35'(M3600);
    st_nxt[4].fs = dd42 * DaySec + $signed({25'd0, st_r[3].tod});
    st_nxt[4].b  = pb[50:43];
    st_nxt[4].hr = ph[33:29];
    st_nxt[4].wd = st_r[3].cmd ? mod7(24'(st_r[3].q) + WdayBias)
                               : mod7(24'(st_r[3].jdn) + 24'd1);
  end

  // Stage 5: span check of computed seconds; day within cycle, seconds of hour
  always_comb begin
    logic [26:0] pc;
    st_nxt[5] = st_r[4];
    pc = 27'(st_r[4].b) * 27'd146097;
    st_nxt[5].f_oor = (st_r[4].fs < 42'(SecLow)) || (st_r[4].fs > 42'(SecHigh));
    st_nxt[5].c     = 16'(st_r[4].a - 23'(pc >> 2));
    st_nxt[5].r2    = 12'(st_r[4].rem - 17'(st_r[4].hr) * 17'd3600);
  end

  // Stage 6: year within century; minute
  always_comb begin
    logic [36:0] pd;
    logic [24:0] pm;
    st_nxt[6] = st_r[5];
    pd = 37'({st_r[5].c, 2'b11}) * 37'(M1461);
    pm = 25'(st_r[5].r2) * 25'(M60);
    st_nxt[6].d  = pd[35:29];
    st_nxt[6].mi = pm[23:18];
  end

  // Stage 7: day within year; second
  always_comb begin
    logic [17:0] pe;
    st_nxt[7] = st_r[6];
    pe = 18'(st_r[6].d) * 18'd1461;
    st_nxt[7].e  = 9'(st_r[6].c - 16'(pe >> 2));
    st_nxt[7].se = 6'(st_r[6].r2 - 12'(st_r[6].mi) * 12'd60);
  end

  // Stage 8: March-based month
  always_comb begin
    logic [10:0] x3;
    logic [22:0] pm;
    st_nxt[8] = st_r[7];
    x3 = 11'(st_r[7].e) * 11'd5 + 11'd2;
    pm = 23'(x3) * 23'(M153);
    st_nxt[8].mm = pm[22:19];
  end

  // Stage 9: assemble the result, zero fields out of span
  always_comb begin
    logic        ge;
    logic [14:0] yv;
    logic [8:0]  dv;
    ge = (st_r[8].mm >= 4'd10);
    yv = 15'(st_r[8].b) * 15'd100 + 15'(st_r[8].d) + 15'(ge) - 15'd4800;
    dv = st_r[8].e - month_offset(st_r[8].mm) + 9'd1;
    sec_out_nxt = '0;
    year_nxt    = '0;
    month_nxt   = '0;
    day_nxt     = '0;
    hour_nxt    = '0;
    minute_nxt  = '0;
    second_nxt  = '0;
    wday_nxt    = '0;
    if (!st_r[8].cmd) begin
      oor_nxt = st_r[8].f_oor;
      if (!st_r[8].f_oor) begin
        sec_out_nxt = st_r[8].fs[38:0];
        wday_nxt    = st_r[8].wd;
      end
    end else begin
      oor_nxt     = !st_r[8].in_rng;
      sec_out_nxt = st_r[8].sec_raw;
      if (st_r[8].in_rng) begin
        year_nxt   = yv[13:0];
        month_nxt  = ge ? 4'(st_r[8].mm - 4'd9) : 4'(st_r[8].mm + 4'd3);
        day_nxt    = dv[4:0];
        hour_nxt   = st_r[8].hr;
        minute_nxt = st_r[8].mi;
        second_nxt = st_r[8].se;
        wday_nxt   = st_r[8].wd;
      end
    end
  end

  // Valid bits: cleared by reset, move with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[7:1], in_valid};
      out_valid_r <= vld_r[8];
    end
  end

  // Payload registers: hold on stall
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 1; i <= 8; i++) begin
        st_r[i] <= st_nxt[i];
      end
      sec_out_r <= sec_out_nxt;
      year_r    <= year_nxt;
      month_r   <= month_nxt;
      day_r     <= day_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      second_r  <= second_nxt;
      wday_r    <= wday_nxt;
      oor_r     <= oor_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_seconds_out  = sec_out_r;
  assign out_year_out     = year_r;
  assign out_month_out    = month_r;
  assign out_day_out      = day_r;
  assign out_hour_out     = hour_r;
  assign out_minute_out   = minute_r;
  assign out_second_out   = second_r;
  assign out_weekday      = wday_r;
  assign out_out_of_range = oor_r;

endmodule

[dv/unix_time_calendar_converter_tb.sv]
// Self-checking bench for unix_time_calendar_converter: both directions of the
// seconds / civil date-time conversion under varied back-pressure.
// Depends on the RTL top level only; expectations come from an in-bench model.
module unix_time_calendar_converter_tb;

  localparam int unsigned CmdToSeconds = 0;
  localparam int unsigned CmdToCivil   = 1;
  localparam longint SpanLow  = -64'sd62167219200;
  localparam longint SpanHigh = 64'sd253402300799;
  localparam longint EpochDay = 64'sd2440588;
  localparam int unsigned Latency = 9;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    logic [38:0] secs;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  wday;
    logic        oor;
  } civil_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic signed [38:0] in_seconds_in = '0;
  logic [13:0] in_year_in = '0;
  logic [3:0] in_month_in = '0;
  logic [4:0] in_day_in = '0;
  logic [4:0] in_hour_in = '0;
  logic [5:0] in_minute_in = '0;
  logic [5:0] in_second_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [38:0] out_seconds_out;
  logic [13:0] out_year_out;
  logic [3:0] out_month_out;
  logic [4:0] out_day_out;
  logic [4:0] out_hour_out;
  logic [5:0] out_minute_out;
  logic [5:0] out_second_out;
  logic [2:0] out_weekday;
  logic out_out_of_range;

  civil_result_t expected_q[$];
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned sent_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  longint cycle_count = 0;

  unix_time_calendar_converter u_dut (.*);

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Julian day number of a civil date, C truncating division
  function automatic longint civil_to_jdn(longint y, longint m, longint d);
    longint a, yy, mm;
    a = (14 - m) / 12;
    yy = y + 4800 - a;
    mm = m + 12 * a - 3;
    return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
  endfunction

  function automatic logic [2:0] day_of_week(longint jdn);
    longint w;
    w = (jdn + 1) % 7;
    if (w < 0) w += 7;
    return 3'(w);
  endfunction

  // Predict the converter result for one request
  function automatic civil_result_t predict_conversion(
      logic cmd, logic [38:0] secs_raw, logic [13:0] y, logic [3:0] mo,
      logic [4:0] d, logic [4:0] h, logic [5:0] mi, logic [5:0] se);
    civil_result_t r;
    longint jdn, s, days, rem, a, b, c, dd, e, m;
    r = '0;
    if (cmd == 1'(CmdToSeconds)) begin
      jdn = civil_to_jdn(longint'(y), longint'(mo), longint'(d));
      s = (jdn - EpochDay) * 86400 + longint'(h) * 3600 + longint'(mi) * 60 + longint'(se);
      if (s < SpanLow || s > SpanHigh) begin
        r.oor = 1'b1;
      end else begin
        r.secs = 39'(s);
        r.wday = day_of_week(jdn);
      end
    end else begin
      s = longint'(signed'(secs_raw));
      r.secs = secs_raw;
      if (s < SpanLow || s > SpanHigh) begin
        r.oor = 1'b1;
      end else begin
        days = s / 86400;
        rem = s % 86400;
        if (rem < 0) begin
          rem += 86400;
          days -= 1;
        end
        jdn = EpochDay + days;
        a = jdn + 32044;
        b = (4 * a + 3) / 146097;
        c = a - (146097 * b) / 4;
        dd = (4 * c + 3) / 1461;
        e = c - (1461 * dd) / 4;
        m = (5 * e + 2) / 153;
        r.day = 5'(e - (153 * m + 2) / 5 + 1);
        r.month = 4'(m + 3 - 12 * (m / 10));
        r.year = 14'(100 * b + dd - 4800 + m / 10);
        r.hour = 5'(rem / 3600);
        r.minute = 6'((rem % 3600) / 60);
        r.second = 6'(rem % 60);
        r.wday = day_of_week(jdn);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch at result %0d: %s got %0d expected %0d", checked_count, what, got, want);
  endtask

  // Send one request and hold it until accepted; valid drops only when idling
  task automatic send_request(logic cmd, logic [38:0] secs, logic [13:0] y, logic [3:0] mo,
                              logic [4:0] d, logic [4:0] h, logic [5:0] mi, logic [5:0] se);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_seconds_in <= secs;
    in_year_in <= y;
    in_month_in <= mo;
    in_day_in <= d;
    in_hour_in <= h;
    in_minute_in <= mi;
    in_second_in <= se;
    expected_q.push_back(predict_conversion(cmd, secs, y, mo, d, h, mi, se));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_civil(int y, int mo, int d, int h, int mi, int se);
    send_request(1'(CmdToSeconds), 39'($urandom), 14'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(se));
  endtask

  task automatic send_seconds(longint s);
    send_request(1'(CmdToCivil), 39'(s), 14'($urandom), 4'($urandom), 5'($urandom),
                 5'($urandom), 6'($urandom), 6'($urandom));
  endtask

  // Receiver ready, with random stalls and a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    civil_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, seconds", longint'(out_seconds_out), 0);
      end else begin
        want = expected_q.pop_front();
        if (out_seconds_out !== want.secs)
          report_mismatch("seconds", longint'(out_seconds_out), longint'(signed'(want.secs)));
        if (out_year_out !== want.year) report_mismatch("year", out_year_out, want.year);
        if (out_month_out !== want.month) report_mismatch("month", out_month_out, want.month);
        if (out_day_out !== want.day) report_mismatch("day", out_day_out, want.day);
        if (out_hour_out !== want.hour) report_mismatch("hour", out_hour_out, want.hour);
        if (out_minute_out !== want.minute)
          report_mismatch("minute", out_minute_out, want.minute);
        if (out_second_out !== want.second)
          report_mismatch("second", out_second_out, want.second);
        if (out_weekday !== want.wday) report_mismatch("weekday", out_weekday, want.wday);
        if (out_out_of_range !== want.oor)
          report_mismatch("out_of_range", out_out_of_range, want.oor);
        checked_count++;
      end
    end
  end

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // Edge dates, wrap-around of day and month, span limits and bit extremes
  task automatic test_directed();
    send_civil(1970, 1, 1, 0, 0, 0);
    send_civil(0, 1, 1, 0, 0, 0);
    send_civil(9999, 12, 31, 23, 59, 59);
    send_civil(2000, 2, 29, 12, 30, 30);
    send_civil(1900, 3, 0, 0, 0, 0);
    send_civil(2024, 0, 15, 31, 63, 63);
    send_civil(2023, 13, 31, 0, 0, 0);
    send_civil(2023, 15, 31, 31, 63, 63);
    send_civil(16383, 15, 31, 31, 63, 63);
    send_civil(10000, 1, 1, 0, 0, 0);
    send_civil(0, 1, 0, 23, 59, 59);
    send_civil(9999, 12, 31, 24, 0, 0);
    send_seconds(0);
    send_seconds(-1);
    send_seconds(SpanLow);
    send_seconds(SpanLow - 1);
    send_seconds(SpanHigh);
    send_seconds(SpanHigh + 1);
    send_seconds(-(64'sd1 <<< 38));
    send_seconds((64'sd1 <<< 38) - 1);
    send_seconds(951782400);
    send_seconds(-86400);
  endtask

  // Mostly in-range requests with random content, some noise anywhere in the fields
  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    longint s;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      case ($urandom_range(9))
        0: send_request(1'($urandom), 39'({$urandom, $urandom}), 14'($urandom), 4'($urandom),
                        5'($urandom), 5'($urandom), 6'($urandom), 6'($urandom));
        1, 2, 3, 4: send_civil($urandom_range(9999), $urandom_range(12, 1), $urandom_range(31, 1),
                               $urandom_range(23), $urandom_range(59), $urandom_range(59));
        default: begin
          s = SpanLow + longint'({$urandom, $urandom} % 64'd315569520000);
          if ($urandom_range(3) == 0) s = longint'($urandom_range(200000)) - 100000;
          send_seconds(s);
        end
      endcase
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the receiver off so the pipeline fills and in_ready drops
  task automatic test_backpressure();
    hold_cycles = 60;
    repeat (40) send_seconds(longint'($urandom));
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    wait_drained();
    test_random(450, 0, 0);
    test_random(400, 74, 0);
    test_backpressure();
    test_random(400, 0, 74);
    test_random(450, 20, 20);
    wait_drained();
    repeat (Latency * 4) @(negedge clk);
    $display("covered %0d requests in both directions, including out-of-span and wrapped fields",
             sent_count);
    $display("%0d results checked under idle, stall and hold-off phases", checked_count);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
